FILE: design/kvg_pkg.sv
//------------------------------------------------------------------------------
// kvg_pkg
// Shared types and constants for the knot vector generator.
//------------------------------------------------------------------------------
`default_nettype none
package kvg_pkg;
   localparam int MaxKnots     = 1024;
   localparam int FractionBits = 24;
   localparam int NumW         = 11;              // numerator magnitude bits
   localparam int DenW         = 11;              // denominator bits
   localparam int DivW         = NumW + FractionBits;  // dividend bits
   localparam int ValW         = 32;

   localparam logic [1:0] KIND_BEZIER  = 2'd0;
   localparam logic [1:0] KIND_EVEN    = 2'd1;
   localparam logic [1:0] KIND_CLAMPED = 2'd2;
   localparam logic [1:0] KIND_CUSTOM  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CUSTOM  = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;
   localparam logic [1:0] ST_CLAMPED = 2'd3;

   localparam logic [1:0] CSR_ORDER   = 2'd0;
   localparam logic [1:0] CSR_POINTS  = 2'd1;
   localparam logic [1:0] CSR_KIND    = 2'd2;
   localparam logic [1:0] CSR_SPACING = 2'd3;

   // classified item: value = sign * (num << FractionBits) / den
   typedef struct packed {
      logic            negative;
      logic [NumW-1:0] num;
      logic [DenW-1:0] den;
      logic [1:0]      status;
   } job_type;
endpackage
`default_nettype wire

FILE: design/knot_vector_generator.sv
//------------------------------------------------------------------------------
// knot_vector_generator
// Returns one B-spline knot value (signed Q8.24) and status per knot index.
//
//   channel | ports                                        | direction
//   req     | req_valid/req_stall/req_knot_index           | in
//   rsp     | rsp_valid/rsp_stall/rsp_knot_value,rsp_status | out
//   csr     | csr_write/csr_index/csr_data                 | in
//
// One item per cycle while the result channel is not stalled; an accepted item
// passes through the queue, the entry stage and 35 one-bit divider stages.
// Reset is synchronous and restores the registers to their reset values.
// A stall on a valid result freezes the divider; the two-entry queue then fills and
// raises req_stall.
//------------------------------------------------------------------------------
`default_nettype none
module knot_vector_generator import kvg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [9:0]        req_knot_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic signed [31:0]     rsp_knot_value,
   output logic [1:0]             rsp_status,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [9:0]        csr_data
);
   logic [5:0] order_ff;
   logic [9:0] points_ff;
   logic [1:0] kind_ff;
   logic       spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff   <= 6'd4;
         points_ff  <= 10'd4;
         kind_ff    <= KIND_CLAMPED;
         spacing_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ORDER:   order_ff   <= csr_data[5:0];
            CSR_POINTS:  points_ff  <= csr_data;
            CSR_KIND:    kind_ff    <= csr_data[1:0];
            CSR_SPACING: spacing_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   job_type job, q_job;
   logic    full, q_valid, q_pop, b_ready;

   kvg_front u_front (
      .curve_order(order_ff), .control_points(points_ff), .knot_kind(kind_ff),
      .spacing_style(spacing_ff), .knot_index(req_knot_index), .job(job));

   assign req_stall = full;
   assign q_pop     = q_valid && b_ready;

   kvg_fifo u_fifo (
      .clock(clock), .reset(reset), .push(req_valid && !full), .push_data(job),
      .full(full), .pop(q_pop), .not_empty(q_valid), .pop_data(q_job));

   kvg_back u_back (
      .clock(clock), .reset(reset), .in_valid(q_pop), .in_job(q_job),
      .in_ready(b_ready), .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_value(rsp_knot_value), .out_status(rsp_status));
endmodule
`default_nettype wire

FILE: design/kvg_front.sv
//------------------------------------------------------------------------------
// kvg_front
// Classifies a knot index into a status and a numerator/denominator pair.
//------------------------------------------------------------------------------
`default_nettype none
module kvg_front import kvg_pkg::*; (
   input  wire logic [5:0]  curve_order,
   input  wire logic [9:0]  control_points,
   input  wire logic [1:0]  knot_kind,
   input  wire logic        spacing_style,
   input  wire logic [9:0]  knot_index,
   output job_type          job
);
   logic [NumW-1:0] ord, cp, cnt, idx, half;

   always_comb begin
      ord  = NumW'(curve_order);
      cp   = NumW'(control_points);
      cnt  = cp + ord;
      idx  = NumW'(knot_index);
      half = cnt >> 1;
      job.negative = 1'b0;
      job.num      = '0;
      job.den      = DenW'(1);
      job.status   = ST_OK;
      if (knot_kind == KIND_CUSTOM) begin
         job.status = ST_CUSTOM;
      end else if (cnt > NumW'(MaxKnots) || idx >= cnt) begin
         job.status = ST_RANGE;
      end else if (knot_kind == KIND_BEZIER) begin
         job.num = (idx < half) ? '0 : NumW'(1);
      end else if (knot_kind == KIND_EVEN) begin
         if (!spacing_style) begin
            job.num = idx;
            job.den = cnt;
         end else begin
            job.den = cp + NumW'(1);
            if (idx < half) begin
               job.negative = 1'b1;
               job.num      = half - idx;
            end else begin
               job.num = idx - half;
            end
         end
      end else begin
         if (ord == '0 || cp < ord) begin
            job.status = ST_CLAMPED;
         end else if (idx < ord) begin
            job.num = '0;
         end else if (idx >= cnt - ord) begin
            job.num = NumW'(1);
         end else begin
            job.num = idx - ord + NumW'(1);
            job.den = cp - ord + NumW'(1);
         end
      end
   end
endmodule
`default_nettype wire

FILE: design/kvg_fifo.sv
//------------------------------------------------------------------------------
// kvg_fifo
// Two-entry queue between the classifier and the divider pipeline.
//------------------------------------------------------------------------------
`default_nettype none
module kvg_fifo import kvg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output job_type      pop_data
);
   job_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
endmodule
`default_nettype wire

FILE: design/kvg_back.sv
//------------------------------------------------------------------------------
// kvg_back
// Pipelined restoring divider, one quotient bit per stage, plus output stage.
// Whole pipeline advances when the output is not stalled or holds no valid result.
//------------------------------------------------------------------------------
`default_nettype none
module kvg_back import kvg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  job_type                in_job,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output logic signed [ValW-1:0] out_value,
   output logic [1:0]             out_status
);
   localparam int Stages = DivW;

   // per stage: valid, partial remainder, dividend/quotient shift word
   logic               vld_ff [Stages+1];
   logic [DenW:0]      rem_ff [Stages+1];
   logic [DivW-1:0]    quo_ff [Stages+1];
   logic [DenW-1:0]    den_ff [Stages+1];
   logic               neg_ff [Stages+1];
   logic [1:0]         st_ff  [Stages+1];
   logic               adv;
   logic [DenW:0]      trial  [Stages];
   logic [DenW+1:0]    diff   [Stages];

   assign adv      = !out_stall || !vld_ff[Stages];
   assign in_ready = adv;

   always_comb begin
      for (int s = 0; s < Stages; s++) begin
         trial[s] = {rem_ff[s][DenW-1:0], quo_ff[s][DivW-1]};
         diff[s]  = {1'b0, trial[s]} - {2'b00, den_ff[s]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= Stages; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 0; s < Stages; s++) vld_ff[s+1] <= vld_ff[s];
      end
      if (adv) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= {in_job.num, FractionBits'(0)};
         den_ff[0] <= in_job.den;
         neg_ff[0] <= in_job.negative;
         st_ff[0]  <= in_job.status;
         for (int s = 0; s < Stages; s++) begin
            if (!diff[s][DenW+1]) begin
               rem_ff[s+1] <= diff[s][DenW:0];
               quo_ff[s+1] <= {quo_ff[s][DivW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial[s];
               quo_ff[s+1] <= {quo_ff[s][DivW-2:0], 1'b0};
            end
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            st_ff[s+1]  <= st_ff[s];
         end
      end
   end

   // saturate, apply sign, zero on nonzero status
   logic [DivW-1:0] q;
   logic [ValW-1:0] mag;
   always_comb begin
      q = quo_ff[Stages];
      if (neg_ff[Stages]) begin
         mag = (q > DivW'(33'h80000000)) ? 32'h80000000 : ValW'(q);
         out_value = -$signed(mag);
      end else begin
         mag = (q > DivW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : ValW'(q);
         out_value = $signed(mag);
      end
      if (st_ff[Stages] != ST_OK) out_value = '0;
      out_status = st_ff[Stages];
      out_valid  = vld_ff[Stages];
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_stall) |=> out_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_status != ST_OK) |-> out_value == '0)
      else $error("nonzero value with error status");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_stall) |=> $stable(out_value))
      else $error("stalled result changed");
endmodule
`default_nettype wire

FILE: tb/sv/tb_knot_vector_generator.sv
//------------------------------------------------------------------------------
// tb_knot_vector_generator
// Self-checking testbench for the knot vector generator. Each accepted knot
// index is run through a local knot predictor. The predicted value and status
// are queued, and every result that comes out is compared with the oldest
// entry. Register settings cover all knot kinds and both spacing styles, and
// include the extreme orders and point counts. Both channels idle at random.
//------------------------------------------------------------------------------
`default_nettype none
module tb_knot_vector_generator;
   import kvg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency  = 37;
   localparam int WdogMax  = 20000;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } knot_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [9:0]        req_knot_index = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic signed [31:0] rsp_knot_value;
   logic [1:0]        rsp_status;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = CSR_ORDER;
   logic [9:0]        csr_data = '0;

   // local copy of the registers
   logic [5:0]  cfg_order;
   logic [9:0]  cfg_points;
   logic [1:0]  cfg_kind;
   logic        cfg_spacing;

   knot_t       expected_knots[$];
   int          error_count = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;
   bit          long_hold = 1'b0;
   bit          rsp_idle_on = 1'b1;
   bit          req_idle_on = 1'b1;
   int          status_hits[4] = '{0, 0, 0, 0};

   knot_vector_generator dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // fixed-point ratio, truncated toward zero, then saturated
   function automatic logic [31:0] fixed_ratio(bit negative, longint mag, longint den);
      longint q;
      q = (mag <<< FractionBits) / den;
      if (negative) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return 32'(q);
   endfunction

   function automatic knot_t predict_knot(logic [9:0] idx);
      knot_t  k;
      longint ord, cp, count, half;
      ord   = cfg_order;
      cp    = cfg_points;
      count = cp + ord;
      half  = count / 2;
      k.value  = '0;
      k.status = ST_OK;
      if (cfg_kind == KIND_CUSTOM) begin
         k.status = ST_CUSTOM;
      end else if (count > MaxKnots || idx >= count) begin
         k.status = ST_RANGE;
      end else if (cfg_kind == KIND_BEZIER) begin
         k.value = (idx < half) ? '0 : fixed_ratio(0, 1, 1);
      end else if (cfg_kind == KIND_EVEN) begin
         if (!cfg_spacing) k.value = fixed_ratio(0, idx, count);
         else if (idx < half) k.value = fixed_ratio(1, half - idx, cp + 1);
         else k.value = fixed_ratio(0, idx - half, cp + 1);
      end else begin
         if (ord == 0 || cp < ord) k.status = ST_CLAMPED;
         else if (idx < ord) k.value = '0;
         else if (idx >= count - ord) k.value = fixed_ratio(0, 1, 1);
         else k.value = fixed_ratio(0, idx - ord + 1, cp - ord + 1);
      end
      return k;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // result checker and receiver stall
   initial begin
      int    wait_cycles;
      knot_t want;
      @(negedge reset);
      forever begin
         wait_cycles = rsp_idle_on ? $urandom_range(0, 11) : 0;
         if ((wait_cycles != 0) || long_hold) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
            repeat ((wait_cycles > 0) ? wait_cycles - 1 : 0) @(posedge clock);
            while (long_hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_seen++;
         if (expected_knots.size() == 0) begin
            report_mismatch("unexpected result", rsp_knot_value, 0);
         end else begin
            want = expected_knots.pop_front();
            status_hits[want.status]++;
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_knot_value !== want.value)
               report_mismatch("knot_value", rsp_knot_value, want.value);
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WdogMax) begin
         $display("Watchdog expired");
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_knot(logic [9:0] idx);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_knot_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_knots.push_back(predict_knot(idx));
      items_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_knots.size() != 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   // drives one write; the caller drops csr_write after the last one
   task automatic write_csr(logic [1:0] idx, logic [9:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_ORDER:   cfg_order   = data[5:0];
         CSR_POINTS:  cfg_points  = data;
         CSR_KIND:    cfg_kind    = data[1:0];
         default:     cfg_spacing = data[0];
      endcase
   endtask

   task automatic set_config(logic [5:0] ord, logic [9:0] cp, logic [1:0] kind, bit sp);
      drain();
      write_csr(CSR_ORDER, 10'(ord));
      write_csr(CSR_POINTS, cp);
      write_csr(CSR_KIND, 10'(kind));
      write_csr(CSR_SPACING, 10'(sp));
      csr_write <= 1'b0;
   endtask

   // directed: reset settings, field extremes, every kind and special case
   task automatic test_directed;
      send_knot(10'd0);
      send_knot(10'd5);
      send_knot(10'd7);
      send_knot(10'd8);
      send_knot(10'd1023);
      set_config(6'd4, 10'd2, KIND_CLAMPED, 0);    // fewer points than order
      send_knot(10'd1);
      set_config(6'd0, 10'd5, KIND_CLAMPED, 0);    // zero order
      send_knot(10'd2);
      set_config(6'd3, 10'd4, KIND_BEZIER, 0);
      send_knot(10'd2);
      send_knot(10'd3);
      set_config(6'd3, 10'd6, KIND_EVEN, 1);       // negative patch values
      send_knot(10'd0);
      send_knot(10'd8);
      send_knot(10'd4);
      set_config(6'd7, 10'd1020, KIND_EVEN, 0);    // count above the limit
      send_knot(10'd0);
      set_config(6'd32, 10'd992, KIND_EVEN, 0);    // count at the limit
      send_knot(10'd1023);
      send_knot(10'd512);
      set_config(6'd1, 10'd1, KIND_CUSTOM, 1);
      send_knot(10'd0);
      send_knot(10'd1023);
   endtask

   // receiver holds off while the sender keeps going
   task automatic test_backpressure;
      set_config(6'd4, 10'd60, KIND_CLAMPED, 0);
      long_hold = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end
         repeat (40) send_knot(10'($urandom_range(0, 63)));
      join
   endtask

   // random phases across settings
   task automatic test_random;
      logic [5:0] ord;
      logic [9:0] cp;
      for (int ph = 0; ph < 25; ph++) begin
         ord = (ph % 5 == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 32));
         case (ph % 4)
            0:       cp = 10'($urandom_range(1, 1023));
            1:       cp = 10'($urandom_range(1, 40));
            2:       cp = 10'($urandom_range(0, 3));
            default: cp = 10'($urandom_range(0, 1023));
         endcase
         req_idle_on = (ph % 6) != 3;
         rsp_idle_on = (ph % 6) != 3;
         set_config(ord, cp, 2'($urandom_range(0, 3)), 1'($urandom));
         repeat (40) begin
            if ($urandom_range(0, 9) < 8)
               send_knot(10'($urandom_range(0, int'(cp) + int'(ord))));
            else
               send_knot(10'($urandom));
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      cfg_order   = 6'd4;
      cfg_points  = 10'd4;
      cfg_kind    = KIND_CLAMPED;
      cfg_spacing = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      drain();
      $display("Sent %0d knot indices, checked %0d results", items_sent, results_seen);
      $display("Status mix ok/custom/range/clamped: %0d/%0d/%0d/%0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      if (error_count == 0 && expected_knots.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
design/kvg_pkg.sv
design/kvg_front.sv
design/kvg_fifo.sv
design/kvg_back.sv
design/knot_vector_generator.sv
tb/sv/tb_knot_vector_generator.sv
